// File: rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ascii converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  // input number width and digit widths
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned TDATA_W = 8;

  // ascii '0', held in the six bits of a digit character
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // a decimal digit at or above this needs the add-3 correction
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // take a new number, clear the digits
    logic step;   // one shift-add-3 step
    logic emit;   // load the output register with the selected digit
    logic last;   // the emitted digit ends the run
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // output register can take a character this cycle
  } stat_t;

endpackage

// File: rtl/b2da_datapath.sv
// ----------------------------------------------------------------------------
// b2da_datapath
// Number shift register, bcd digit registers with shift-add-3, leading digit
// search and the output character register.
// ----------------------------------------------------------------------------
module b2da_datapath import b2da_pkg::*; #(
  parameter int unsigned NDIG  = 10,
  parameter int unsigned IDX_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [IDX_W-1:0]   sel,
  input  logic [NUM_W-1:0]   number,
  output stat_t              stat,
  output logic [IDX_W-1:0]   lead,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [5:0] digit_char, [7:6] zero
  output logic               m_tlast    // last_digit
);

  logic [NUM_W-1:0]   num;
  logic [DIGIT_W-1:0] digits [NDIG];
  logic [DIGIT_W-1:0] adj    [NDIG];
  logic [CHAR_W-1:0]  char_next;

  // add-3 correction on every digit ahead of the shift
  always_comb begin
    for (int i = 0; i < int'(NDIG); i++) begin
      adj[i] = (digits[i] >= ADJ_LIMIT) ? digits[i] + ADJ_ADD : digits[i];
    end
  end

  // shift number and digits together, one input bit per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num <= number;
      for (int i = 0; i < int'(NDIG); i++) begin
        digits[i] <= '0;
      end
    end else if (cmd.step) begin
      num <= {num[NUM_W-2:0], 1'b0};
      digits[0] <= {adj[0][DIGIT_W-2:0], num[NUM_W-1]};
      for (int i = 1; i < int'(NDIG); i++) begin
        digits[i] <= {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
      end
    end
  end

  // highest nonzero digit, zero when all are zero
  always_comb begin
    lead = '0;
    for (int i = 1; i < int'(NDIG); i++) begin
      if (digits[i] != '0) begin
        lead = IDX_W'(i);
      end
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;
  assign char_next     = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits[sel]};

  // output register, refilled as soon as the previous transfer is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {{(TDATA_W-CHAR_W){1'b0}}, char_next};
      m_tlast <= cmd.last;
    end
  end

endmodule

// File: rtl/b2da_ctrl.sv
// ----------------------------------------------------------------------------
// b2da_ctrl
// Sequencer: accept, 32 conversion steps, leading digit scan, digit emission.
// ----------------------------------------------------------------------------
module b2da_ctrl import b2da_pkg::*; #(
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  stat_t            stat,
  input  logic [IDX_W-1:0] lead,
  output cmd_t             cmd,
  output logic [IDX_W-1:0] sel
);

  localparam int unsigned BIT_W = $clog2(NUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(NUM_W - 1);

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [BIT_W-1:0] bit_cnt;
  logic [IDX_W-1:0] pos;

  assign s_tready = (state == ST_IDLE);
  assign sel      = pos;

  // command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (bit_cnt == BIT_LAST) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = (pos == '0);
          if (pos == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // step counter and digit position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bit_cnt <= '0;
    end else if (cmd.step) begin
      bit_cnt <= bit_cnt + 1'b1;
    end
    if (state == ST_SCAN) begin
      pos <= lead;
    end else if (cmd.emit) begin
      pos <= pos - 1'b1;
    end
  end

endmodule

// File: rtl/binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Converts an unsigned 32-bit number to ascii decimal digits, most
// significant first, no leading zeros, a lone '0' for zero.
//
//   channel  dir  tdata               tuser  tlast
//   s_axis   in   [31:0] number       -      -
//   m_axis   out  [5:0] digit_char    -      last_digit
//
// One number passes through accept, 32 shift-add-3 steps over the bcd digit
// registers and the leading digit scan; then its digits (1 to 10) leave one
// per cycle while the output register is free to take them.
// Reset is synchronous; it clears the sequencer and the output valid.
// A stalled output holds the sequencer in emission; the last digit sits in
// the output register while the next number is already being accepted.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit import b2da_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [NUM_W-1:0]   s_tdata,   // [31:0] number
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [5:0] digit_char, [7:6] zero
  output logic               m_tlast    // last_digit
);

  // a 32-bit value never needs more than ten digits
  localparam int unsigned NDIG  = (MAX_DIGITS > 10) ? 10 :
                                  ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
  localparam int unsigned IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;

  cmd_t             cmd;
  stat_t            stat;
  logic [IDX_W-1:0] sel;
  logic [IDX_W-1:0] lead;

  // sequencer
  b2da_ctrl #(
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .lead     (lead),
    .cmd      (cmd),
    .sel      (sel)
  );

  // conversion and output datapath
  b2da_datapath #(
    .NDIG  (NDIG),
    .IDX_W (IDX_W)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sel      (sel),
    .number   (s_tdata),
    .stat     (stat),
    .lead     (lead),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
